FILE: rtl/fixed_block_pool_allocator_defines.svh
// Assertion macros for the block pool allocator.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Condition must hold on every clock edge outside reset.
`define FBPA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the following edge.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fbpa_pkg.sv
// Types, constants and helpers for the fixed block pool allocator.
package fbpa_pkg;

  localparam int NUM_CHUNKS   = 64;
  localparam int CHUNK_BYTES  = 64;
  localparam int HEADER_BYTES = 16;

  localparam int HANDLE_W = 12;
  localparam int IDX_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CNT_W    = 7;

  localparam logic [HANDLE_W-1:0] HEADER_H = HANDLE_W'(HEADER_BYTES);
  localparam logic [HANDLE_W-1:0] CHUNK_H  = HANDLE_W'(CHUNK_BYTES);
  localparam logic [HANDLE_W:0]   POOL_END = (HANDLE_W+1)'(NUM_CHUNKS * CHUNK_BYTES);
  localparam logic [CNT_W-1:0]    NUM_CHUNKS_C = CNT_W'(NUM_CHUNKS);

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_EMPTY        = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR     = 2'd2;
  localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

  typedef struct packed {
    logic                action;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] granted_handle;
    logic [CNT_W-1:0]    free_count;
  } rsp_t;

  // One free-list link: successor index and end-of-list mark.
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] link;
  } link_word_t;

  function automatic link_word_t reset_word(input logic [IDX_W-1:0] idx);
    link_word_t w;
    w.last = (int'(idx) == NUM_CHUNKS - 1);
    w.link = IDX_W'(int'(idx) + 1);
    return w;
  endfunction

endpackage

FILE: rtl/fixed_block_pool_allocator.sv
// A result is presented in the cycle after its request transfer when no earlier
// result waits. Throughput: one request per cycle while req_stall is low; it rises
// when the two-entry result queue, which absorbs output stalls, is full. The head
// link and its successor link are held in registers, so each pop needs one registered
// link-memory read, issued ahead of use. Reset (synchronous, rst high): all chunks
// free, list 0..N-1 in order, restored by per-entry written bits; no clearing pass.
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  link_word_t mem [NUM_CHUNKS];
  logic [NUM_CHUNKS-1:0] written;
  logic [NUM_CHUNKS-1:0] chunk_free, chunk_free_next;

  logic [IDX_W-1:0] head, head_next;
  link_word_t       head_word, head_word_next;
  link_word_t       succ_word;
  logic             list_empty, list_empty_next;
  logic [CNT_W-1:0] free_chunks, free_chunks_next;

  rsp_t       q [2];
  logic       wptr, rptr;
  logic [1:0] cnt;

  logic                accept, rsp_take;
  logic                pop, push;
  logic [IDX_W-1:0]    rel_idx;
  logic [HANDLE_W-1:0] off, off_rem, off_div;
  rsp_t                result;

  assign req_stall = (cnt == 2'd2);
  assign rsp_valid = (cnt != 2'd0);
  assign rsp       = q[rptr];
  assign accept    = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;

  assign off     = req.handle - HEADER_H;
  assign off_rem = off % CHUNK_H;
  assign off_div = off / CHUNK_H;
  assign rel_idx = off_div[IDX_W-1:0];

  always_comb begin
    head_next        = head;
    head_word_next   = head_word;
    list_empty_next  = list_empty;
    free_chunks_next = free_chunks;
    chunk_free_next  = chunk_free;
    pop              = 1'b0;
    push             = 1'b0;
    result.status         = ST_OK;
    result.granted_handle = '0;
    if (accept) begin
      if (req.action == ACT_ALLOC) begin
        if (list_empty) begin
          result.status = ST_EMPTY;
        end else begin
          pop = 1'b1;
          result.granted_handle = HANDLE_W'(head) * CHUNK_H + HEADER_H;
          chunk_free_next[head] = 1'b0;
          if (head_word.last) begin
            list_empty_next = 1'b1;
          end else begin
            head_next      = head_word.link;
            head_word_next = succ_word;
          end
          if (free_chunks != '0) begin
            free_chunks_next = free_chunks - CNT_W'(1);
          end
        end
      end else begin
        if (req.handle < HEADER_H || {1'b0, off} >= POOL_END || off_rem != '0) begin
          result.status = ST_BAD_ADDR;
        end else if (chunk_free[rel_idx]) begin
          result.status = ST_ALREADY_FREE;
        end else begin
          push                     = 1'b1;
          chunk_free_next[rel_idx] = 1'b1;
          head_next                = rel_idx;
          head_word_next.last      = list_empty;
          head_word_next.link      = head;
          list_empty_next          = 1'b0;
          free_chunks_next         = free_chunks + CNT_W'(1);
        end
      end
    end
    result.free_count = free_chunks_next;
  end

  // Free-list state
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      head_word   <= reset_word('0);
      list_empty  <= 1'b0;
      free_chunks <= NUM_CHUNKS_C;
      chunk_free  <= '1;
      written     <= '0;
    end else begin
      head        <= head_next;
      head_word   <= head_word_next;
      list_empty  <= list_empty_next;
      free_chunks <= free_chunks_next;
      chunk_free  <= chunk_free_next;
      if (push) begin
        written[rel_idx] <= 1'b1;
      end
    end
  end

  // Successor of the new head: registered link read, or the old head word on a push.
  always_ff @(posedge clk) begin
    if (rst) begin
      succ_word <= reset_word(IDX_W'(1));
    end else if (pop) begin
      succ_word <= written[succ_word.link] ? mem[succ_word.link] : reset_word(succ_word.link);
    end else if (push) begin
      succ_word <= head_word;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[rel_idx] <= head_word_next;
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (accept) begin
        wptr <= ~wptr;
      end
      if (rsp_take) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(accept) - 2'(rsp_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wptr] <= result;
    end
  end

  `FBPA_ASSERT_ALWAYS(a_count_matches_bits, CNT_W'($countones(chunk_free)) == free_chunks, "free count disagrees with free bits")
  `FBPA_ASSERT_ALWAYS(a_empty_matches_count, list_empty == (free_chunks == '0), "empty flag disagrees with free count")
  `FBPA_ASSERT_ALWAYS(a_head_is_free, list_empty || chunk_free[head], "list head is not a free chunk")
  `FBPA_ASSERT_NEXT(a_pop_clears_bit, pop, !chunk_free[$past(head)], "allocated chunk still marked free")

endmodule

FILE: tb/fixed_block_pool_allocator_checker.sv
// Checker for the block pool allocator: predicts each result and compares it.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_checker import fbpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  logic [IDX_W-1:0] link_map [NUM_CHUNKS];
  logic             last_map [NUM_CHUNKS];
  logic             free_map [NUM_CHUNKS];
  logic [IDX_W-1:0] head_idx;
  logic             pool_empty;
  int               free_total;

  rsp_t expected_rsp_q [$];
  int   errors = 0;
  int   in_flight = 0;

  assign mismatches  = errors;
  assign outstanding = in_flight;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] %s: got %0d, want %0d", $time, field, got, want);
    errors++;
  endtask

  function automatic void pool_reset();
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      link_map[i] = IDX_W'(i + 1);
      last_map[i] = (i == NUM_CHUNKS - 1);
      free_map[i] = 1'b1;
    end
    head_idx   = '0;
    pool_empty = 1'b0;
    free_total = NUM_CHUNKS;
  endfunction

  function automatic rsp_t pool_apply(input req_t item);
    rsp_t res;
    int   off;
    int   idx;
    res.status         = ST_OK;
    res.granted_handle = '0;
    if (item.action == ACT_ALLOC) begin
      if (pool_empty) begin
        res.status = ST_EMPTY;
      end else begin
        idx = int'(head_idx);
        free_map[idx] = 1'b0;
        if (last_map[idx]) pool_empty = 1'b1;
        else head_idx = link_map[idx];
        if (free_total > 0) free_total--;
        res.granted_handle = HANDLE_W'(idx * CHUNK_BYTES + HEADER_BYTES);
      end
    end else begin
      off = int'(item.handle) - HEADER_BYTES;
      if (off < 0 || off >= NUM_CHUNKS * CHUNK_BYTES || (off % CHUNK_BYTES) != 0) begin
        res.status = ST_BAD_ADDR;
      end else begin
        idx = off / CHUNK_BYTES;
        if (free_map[idx]) begin
          res.status = ST_ALREADY_FREE;
        end else begin
          link_map[idx] = head_idx;
          last_map[idx] = pool_empty;
          free_map[idx] = 1'b1;
          head_idx      = IDX_W'(idx);
          pool_empty    = 1'b0;
          free_total++;
        end
      end
    end
    res.free_count = CNT_W'(free_total);
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      pool_reset();
      expected_rsp_q.delete();
      in_flight = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", int'(rsp.status), int'(want.status));
          if (rsp.granted_handle !== want.granted_handle)
            report_mismatch("granted_handle", int'(rsp.granted_handle),
                            int'(want.granted_handle));
          if (rsp.free_count !== want.free_count)
            report_mismatch("free_count", int'(rsp.free_count), int'(want.free_count));
        end
      end
      if (req_valid && !req_stall)
        expected_rsp_q.push_back(pool_apply(req));
      in_flight = expected_rsp_q.size();
    end
  end

endmodule

FILE: tb/fixed_block_pool_allocator_tb.sv
// Testbench top for the block pool allocator: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 440;
  localparam int HOLD_CYCLES   = 240;
  localparam int SETTLE_CYCLES = 10;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int mismatches;
  int outstanding;

  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int phase         = -1;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int cycles        = 0;

  fixed_block_pool_allocator DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  fixed_block_pool_allocator_checker scoreboard (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver flow control; one long hold-off in the second phase fills the block
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase == 1 && !hold_done) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  task automatic send_req(input logic action, input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{action: action, handle: handle};
    do @(posedge clk); while (req_stall);
  endtask

  function automatic logic [HANDLE_W-1:0] chunk_handle(input int idx);
    return HANDLE_W'(idx * CHUNK_BYTES + HEADER_BYTES);
  endfunction

  initial begin
    int alloc_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(ACT_RELEASE, chunk_handle(0));
    send_req(ACT_ALLOC, '0);
    send_req(ACT_ALLOC, '1);
    send_req(ACT_RELEASE, chunk_handle(0));
    send_req(ACT_RELEASE, chunk_handle(0));
    send_req(ACT_RELEASE, chunk_handle(1));
    send_req(ACT_RELEASE, '0);
    send_req(ACT_RELEASE, HANDLE_W'(HEADER_BYTES - 1));
    send_req(ACT_RELEASE, '1);
    send_req(ACT_RELEASE, HANDLE_W'(HEADER_BYTES + 1));
    send_req(ACT_RELEASE, chunk_handle(NUM_CHUNKS - 1));
    send_req(ACT_RELEASE, HANDLE_W'(NUM_CHUNKS * CHUNK_BYTES - CHUNK_BYTES / 2));
    send_req(ACT_ALLOC, '0);
    send_req(ACT_ALLOC, '0);
    send_req(ACT_ALLOC, 12'h555);
    send_req(ACT_RELEASE, chunk_handle(2));
    send_req(ACT_RELEASE, chunk_handle(1));
    send_req(ACT_RELEASE, chunk_handle(0));
    send_req(ACT_ALLOC, '0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 10;
          rcv_idle_pct  = 47;
        end
        1: begin
          send_idle_pct = 47;
          rcv_idle_pct  = 10;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
        end
      endcase
      phase = p;
      alloc_pct = 50;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) begin
          case ($urandom_range(0, 2))
            0:       alloc_pct = 95;
            1:       alloc_pct = 20;
            default: alloc_pct = 60;
          endcase
        end
        if ($urandom_range(0, 99) < alloc_pct)
          send_req(ACT_ALLOC, HANDLE_W'($urandom_range(0, 4095)));
        else if ($urandom_range(0, 99) < 80)
          send_req(ACT_RELEASE, chunk_handle($urandom_range(0, NUM_CHUNKS - 1)));
        else
          send_req(ACT_RELEASE, HANDLE_W'($urandom_range(0, 4095)));
      end
    end
    req_valid <= 1'b0;
    rcv_idle_pct = 0;

    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
